// ----- rtl/button_press_lock_long_press_macros.svh -----
// ----------------------------------------------------------------------------
// button press lock assertion macros
// shared assertion forms for the button qualifier checker
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_LOCK_LONG_PRESS_MACROS_SVH
`define BUTTON_PRESS_LOCK_LONG_PRESS_MACROS_SVH

// checked only while out of reset
`define BPLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define BPLP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/bplp_pkg.sv -----
// ----------------------------------------------------------------------------
// bplp_pkg
// types and constants of the button press lock and long press qualifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bplp_pkg;

    localparam int BUTTONS    = 3;
    localparam int ADDR_W     = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int REL_W      = 10;
    localparam int HOLD_W     = 16;
    localparam int CFG_W      = 16;
    localparam int MASK_W     = 3;
    localparam int OUT_DEPTH  = 2;

    localparam logic [REL_W-1:0]  REL_RESET  = 10'd100;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;

    // request opcodes
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_READ_SHORT = 2'd1;
    localparam logic [1:0] OP_READ_LONG  = 2'd2;

    // configuration register indexes
    localparam logic CFG_RELEASE = 1'b0;
    localparam logic CFG_LONG    = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] button_index;
        logic [2:0] pin_levels;
    } t_in;

    typedef struct packed {
        logic              flag_read;
        logic [MASK_W-1:0] locked_mask;
    } t_out;

    // per-button state word held in the state ram
    typedef struct packed {
        logic              locked;
        logic              prev_level;
        logic              pressed;
        logic              long_flag;
        logic              long_sent;
        logic              rel_timing;
        logic [REL_W-1:0]  rel_count;
        logic [HOLD_W-1:0] hold_count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry ENTRY_RESET = '{
        locked:     1'b0,
        prev_level: 1'b1,
        pressed:    1'b0,
        long_flag:  1'b0,
        long_sent:  1'b0,
        rel_timing: 1'b0,
        rel_count:  '0,
        hold_count: '0
    };

endpackage

// ----- rtl/button_press_lock_long_press.sv -----
// ----------------------------------------------------------------------------
// button_press_lock_long_press
// qualifies active-low buttons: press lock, stable release, long press flags
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in_data  (t_in)
//  out      | output    | o_out_valid / i_out_ready | o_out_data (t_out)
//  cfg      | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  a tick request does one state ram read-modify-write per button, in turn,
//  through the single read port; a read request reads one entry.
//  the last ram read is registered, then its result in the result queue.
//  ram entries not yet written read as their reset value through per-entry
//  valid bits, so reset needs no clearing pass.
//  at most two requests are in flight, queue included, so reads in a row
//  are taken with pauses between them; a full queue holds off new requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_press_lock_long_press
    import bplp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam logic [ADDR_W-1:0] LAST_BTN = ADDR_W'(BUTTONS - 1);
    localparam logic [1:0]        OUT_MAX  = 2'(OUT_DEPTH);

    // configuration
    logic [REL_W-1:0]  r_rel_ms;
    logic [HOLD_W-1:0] r_long_ms;

    // issue sequencer
    logic              r_busy;
    logic [ADDR_W-1:0] r_cnt;
    logic [2:0]        r_pins;
    logic [1:0]        r_outs;

    logic              accept;
    logic              in_range;
    logic              iss_valid;
    logic [ADDR_W-1:0] iss_addr;
    logic [1:0]        iss_op;
    logic              iss_level;
    logic              iss_acc;
    logic              iss_last;

    // modify stage
    logic              r_s2_valid;
    logic [1:0]        r_s2_op;
    logic [ADDR_W-1:0] r_s2_addr;
    logic              r_s2_level;
    logic              r_s2_acc;
    logic              r_s2_last;
    logic              r_byp;
    t_entry            r_byp_data;

    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             cur;
    t_entry             nxt;
    logic               flag;
    logic               wr_en;
    logic [HOLD_W-1:0]  hold_inc;
    logic [REL_W-1:0]   rel_inc;
    logic               same_addr;

    logic [BUTTONS-1:0] r_valid;
    logic [BUTTONS-1:0] r_lock_mask;
    logic [BUTTONS-1:0] mask_now;

    // result queue
    t_out       r_q [OUT_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_qcnt;
    logic       push;
    logic       pop;

    assign o_in_ready = !r_busy && (r_outs < OUT_MAX);
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_in_data.button_index) < BUTTONS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_ms  <= REL_RESET;
            r_long_ms <= HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RELEASE: r_rel_ms  <= i_cfg_data[REL_W-1:0];
                CFG_LONG:    r_long_ms <= i_cfg_data[HOLD_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        iss_valid = 1'b0;
        iss_addr  = '0;
        iss_op    = i_in_data.op;
        iss_level = i_in_data.pin_levels[0];
        iss_acc   = 1'b0;
        iss_last  = 1'b1;
        if (r_busy) begin
            iss_valid = 1'b1;
            iss_addr  = r_cnt;
            iss_op    = OP_TICK;
            iss_level = r_pins[r_cnt];
            iss_acc   = 1'b1;
            iss_last  = (r_cnt == LAST_BTN);
        end else if (accept) begin
            iss_valid = 1'b1;
            case (i_in_data.op) inside
                OP_TICK: begin
                    iss_acc  = 1'b1;
                    iss_last = (BUTTONS == 1);
                end
                OP_READ_SHORT, OP_READ_LONG: begin
                    iss_addr = ADDR_W'(i_in_data.button_index);
                    iss_acc  = in_range;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == LAST_BTN) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (accept && i_in_data.op == OP_TICK && BUTTONS > 1) begin
            r_busy <= 1'b1;
            r_cnt  <= ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pins <= i_in_data.pin_levels;
        end
    end

    bplp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUTTONS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s2_addr),
        .i_wdata (nxt),
        .i_raddr (iss_addr),
        .o_rdata (ram_rdata)
    );

    // forward the write in flight, or the reset value for a fresh entry
    assign same_addr = wr_en && (r_s2_addr == iss_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= iss_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_op    <= iss_op;
        r_s2_addr  <= iss_addr;
        r_s2_level <= iss_level;
        r_s2_acc   <= iss_acc;
        r_s2_last  <= iss_last;
        r_byp      <= same_addr || !r_valid[iss_addr];
        r_byp_data <= same_addr ? nxt : ENTRY_RESET;
    end

    assign cur      = r_byp ? r_byp_data : t_entry'(ram_rdata);
    assign hold_inc = (cur.hold_count != '1) ? cur.hold_count + 1'b1 : cur.hold_count;
    assign rel_inc  = (cur.rel_count != '1) ? cur.rel_count + 1'b1 : cur.rel_count;
    assign wr_en    = r_s2_valid && r_s2_acc;

    always_comb begin
        nxt  = cur;
        flag = 1'b0;
        case (r_s2_op)
            OP_TICK: begin
                if (!cur.locked) begin
                    // falling edge on a released button
                    if (cur.prev_level && !r_s2_level) begin
                        nxt.locked     = 1'b1;
                        nxt.pressed    = 1'b1;
                        nxt.hold_count = '0;
                        nxt.rel_timing = 1'b0;
                        nxt.long_sent  = 1'b0;
                    end
                end else begin
                    nxt.hold_count = hold_inc;
                    if (!r_s2_level) begin
                        nxt.rel_timing = 1'b0;
                        if (!cur.long_sent && hold_inc >= r_long_ms) begin
                            nxt.long_flag = 1'b1;
                            nxt.long_sent = 1'b1;
                            nxt.pressed   = 1'b0;
                        end
                    end else if (!cur.rel_timing) begin
                        nxt.rel_timing = 1'b1;
                        nxt.rel_count  = '0;
                    end else begin
                        nxt.rel_count = rel_inc;
                        if (rel_inc >= r_rel_ms) begin
                            nxt.locked     = 1'b0;
                            nxt.rel_timing = 1'b0;
                        end
                    end
                end
                nxt.prev_level = r_s2_level;
            end
            // an out-of-range button reads zero
            OP_READ_SHORT: begin
                flag        = r_s2_acc && cur.pressed;
                nxt.pressed = 1'b0;
            end
            OP_READ_LONG: begin
                if (r_s2_acc && cur.long_flag) begin
                    flag          = 1'b1;
                    nxt.long_flag = 1'b0;
                    nxt.pressed   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        mask_now = r_lock_mask;
        if (wr_en) begin
            mask_now[r_s2_addr] = nxt.locked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_lock_mask <= '0;
        end else begin
            r_lock_mask <= mask_now;
            if (wr_en) begin
                r_valid[r_s2_addr] <= 1'b1;
            end
        end
    end

    assign push = r_s2_valid && r_s2_last;
    assign pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{flag_read: flag, locked_mask: MASK_W'(mask_now)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= '0;
            r_outs <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_qcnt <= r_qcnt + {1'b0, push} - {1'b0, pop};
            r_outs <= r_outs + {1'b0, accept} - {1'b0, pop};
        end
    end

    assign o_out_valid = (r_qcnt != '0);
    assign o_out_data  = r_q[r_rp];

endmodule

// ----- rtl/bplp_ram.sv -----
// ----------------------------------------------------------------------------
// bplp_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bplp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/bplp_checker.sv -----
// ----------------------------------------------------------------------------
// bplp_checker
// port-level checks for the button press lock qualifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_press_lock_long_press_macros.svh"

module bplp_checker
    import bplp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic [2:0] r_pend;

    // requests taken but results not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {2'b00, i_in_valid && o_in_ready}
                             - {2'b00, o_out_valid && i_out_ready};
        end
    end

    `BPLP_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result dropped while stalled")

    `BPLP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result shown after reset")

    `BPLP_ASSERT(a_tick_busy, i_in_valid && o_in_ready && i_in_data.op == OP_TICK |=> !o_in_ready, "tick request did not hold off the next one")

    `BPLP_ASSERT(a_no_spurious, o_out_valid |-> r_pend != 3'd0 && r_pend <= 3'(OUT_DEPTH), "result count does not match requests")

endmodule

bind button_press_lock_long_press bplp_checker u_bplp_checker (.*);
